### rtl/assert_macros.svh
// Assertion macros shared by the placer RTL modules.
// Depends on nothing; included by each module that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/gllp_pkg.sv
// Package of the group least-loaded domain placer: codes, widths, defaults and
// the control and status structs between the top level and the count unit.
// Depends on nothing.
package gllp_pkg;

   localparam int unsigned MAX_DOMAINS_DEF = 64;
   localparam int unsigned MAX_GROUP_DEF   = 256;
   localparam int unsigned MAX_GROUPS_DEF  = 65535;

   localparam int unsigned ELEMENTS = 65536;
   localparam int MAP_AW = $clog2(ELEMENTS);

   localparam int IDX_W  = 16;
   localparam int DOM_W  = 7;
   localparam int SIZE_W = 9;

   localparam logic [1:0] OP_WRITE  = 2'd0;
   localparam logic [1:0] OP_MEMBER = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;
   localparam logic [1:0] OP_CLEAR  = 2'd3;

   localparam logic [1:0] KIND_READ    = 2'd0;
   localparam logic [1:0] KIND_PLACED  = 2'd1;
   localparam logic [1:0] KIND_DROPPED = 2'd2;

   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_OVERFLOW = 2'd1;
   localparam logic [1:0] ERR_DOMAIN   = 2'd2;

   typedef struct packed {
      logic             start;
      logic             mark;
      logic [DOM_W-1:0] mark_dom;
      logic             clear_occ;
      logic             clear_counts;
   } scan_ctrl_type;

   typedef struct packed {
      logic done;
      logic found;
   } scan_stat_type;

endpackage

### rtl/gllp_counts.sv
// Count unit: per-domain group counts in a one-port memory, occupied flags,
// and the sequential least-loaded scan with saturating bump.
// Depends on gllp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gllp_counts #(
   parameter int unsigned MAX_DOMAINS = gllp_pkg::MAX_DOMAINS_DEF,
   parameter int unsigned MAX_GROUPS  = gllp_pkg::MAX_GROUPS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  gllp_pkg::scan_ctrl_type            ctrl,
   input  logic [$clog2(MAX_DOMAINS + 1)-1:0] lim,
   output gllp_pkg::scan_stat_type            status,
   output logic [$clog2(MAX_DOMAINS + 1)-1:0] best
);

   localparam int DW = $clog2(MAX_DOMAINS + 1);
   localparam int CW = $clog2(64'(MAX_GROUPS) + 64'd1);

   localparam logic [1:0] SC_IDLE  = 2'd0;
   localparam logic [1:0] SC_READ  = 2'd1;
   localparam logic [1:0] SC_DRAIN = 2'd2;
   localparam logic [1:0] SC_FIN   = 2'd3;

   logic [CW-1:0]      cnt_mem [MAX_DOMAINS + 1];
   logic [MAX_DOMAINS:0] cnt_vld_ff, cnt_vld_in;
   logic [MAX_DOMAINS:0] occ_ff, occ_in;
   logic [1:0]         state_ff, state_in;
   logic [DW-1:0]      addr_ff, addr_in;
   logic [DW-1:0]      rdom_ff;
   logic               rvld_ff, rvld_in;
   logic [CW-1:0]      rdata_ff;
   logic [DW-1:0]      best_ff, best_in;
   logic [CW-1:0]      bestcnt_ff, bestcnt_in;
   logic [CW-1:0]      cnt;
   logic [CW-1:0]      bumped;
   logic [DW-1:0]      mark_idx;
   logic               take;
   logic               cnt_wr;

   assign cnt      = cnt_vld_ff[rdom_ff] ? rdata_ff : '0;
   assign take     = rvld_ff && occ_ff[rdom_ff] && ((best_ff == '0) || (cnt < bestcnt_ff));
   assign bumped   = (64'(bestcnt_ff) < 64'(MAX_GROUPS)) ? bestcnt_ff + CW'(1) : bestcnt_ff;
   assign mark_idx = DW'(ctrl.mark_dom);
   assign best     = best_ff;

   always_comb begin
      state_in   = state_ff;
      addr_in    = addr_ff;
      best_in    = best_ff;
      bestcnt_in = bestcnt_ff;
      rvld_in    = 1'b0;
      cnt_wr     = 1'b0;
      occ_in     = occ_ff;
      cnt_vld_in = cnt_vld_ff;
      status     = '0;

      if (ctrl.clear_occ) begin
         occ_in = '0;
      end else if (ctrl.mark) begin
         occ_in[mark_idx] = 1'b1;
      end
      if (ctrl.clear_counts) begin
         cnt_vld_in = '0;
      end
      if (take) begin
         best_in    = rdom_ff;
         bestcnt_in = cnt;
      end

      unique case (state_ff)
         SC_IDLE: begin
            if (ctrl.start) begin
               addr_in  = DW'(1);
               best_in  = '0;
               state_in = (lim == '0) ? SC_FIN : SC_READ;
            end
         end
         SC_READ: begin
            rvld_in = 1'b1;
            if (addr_ff == lim) begin
               state_in = SC_DRAIN;
            end else begin
               addr_in = addr_ff + DW'(1);
            end
         end
         SC_DRAIN: begin
            state_in = SC_FIN;
         end
         SC_FIN: begin
            status.done  = 1'b1;
            status.found = (best_ff != '0);
            cnt_wr       = (best_ff != '0);
            if (best_ff != '0) begin
               cnt_vld_in[best_ff] = 1'b1;
            end
            state_in = SC_IDLE;
         end
         default: begin
            state_in = SC_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cnt_wr) begin
         cnt_mem[best_ff] <= bumped;
      end else if (state_ff == SC_READ) begin
         rdata_ff <= cnt_mem[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= SC_IDLE;
         rvld_ff    <= 1'b0;
         occ_ff     <= '0;
         cnt_vld_ff <= '0;
         best_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         rvld_ff    <= rvld_in;
         occ_ff     <= occ_in;
         cnt_vld_ff <= cnt_vld_in;
         best_ff    <= best_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff    <= addr_in;
      rdom_ff    <= addr_ff;
      bestcnt_ff <= bestcnt_in;
   end

   `ASSERT_IMPL(a_scan_range, clock, reset, state_ff == SC_READ, addr_ff != '0 && addr_ff <= lim)
   `ASSERT_NEXT(a_done_pulse, clock, reset, status.done, !status.done)
   `ASSERT_IMPL(a_found_range, clock, reset, status.done && status.found, best_ff <= lim)

endmodule

### rtl/group_least_loaded_domain_placer.sv
// Top level of the group least-loaded domain placer: element-to-domain map
// memory, group member buffer, item sequencer and result register.
// Depends on gllp_pkg, gllp_counts and assert_macros.svh.
`include "assert_macros.svh"

// Write and clear transactions may follow back to back.
// A read passes through the map memory read and then the result register.
// A group member passes through the read of the map memory.
// The last member of a group adds a scan of the count memory, one domain per
// cycle, of the domains in use (at most MAX_DOMAINS), and then a rewrite of the
// map, one member per cycle, followed by the load of the result. A dropped
// group adds only the load of its result. The result register lets the next
// transaction enter while a result waits to be taken.
module group_least_loaded_domain_placer #(
   parameter int unsigned MAX_DOMAINS = gllp_pkg::MAX_DOMAINS_DEF,
   parameter int unsigned MAX_GROUP   = gllp_pkg::MAX_GROUP_DEF,
   parameter int unsigned MAX_GROUPS  = gllp_pkg::MAX_GROUPS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // element_index[15:0], domain[22:16], zero[23]
   input  logic [1:0]  req_tuser,   // operation[1:0]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // domain_res[6:0], group_size[15:7], error_code[17:16]
   output logic [1:0]  rsp_tuser,   // result_kind[1:0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [6:0]  csr_data
);

   localparam int DW = $clog2(MAX_DOMAINS + 1);
   localparam int FW = $clog2(MAX_GROUP + 1);
   localparam int BW = $clog2(MAX_GROUP);
   localparam int AW = gllp_pkg::MAP_AW;
   localparam int IW = gllp_pkg::IDX_W;
   localparam int VW = gllp_pkg::DOM_W;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MEMB = 3'd1;
   localparam logic [2:0] ST_SCAN = 3'd2;
   localparam logic [2:0] ST_REWR = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   logic [VW-1:0] map_mem [gllp_pkg::ELEMENTS];
   logic [IW-1:0] buf_mem [MAX_GROUP];

   logic [2:0]    state_ff, state_in;
   logic [6:0]    active_ff, active_in;
   logic          last_ff, last_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [1:0]    fault_ff, fault_in;
   logic [FW-1:0] rk_ff, rk_in;
   logic          rvld_ff, rvld_in;
   logic [1:0]    res_kind_ff, res_kind_in;
   logic [VW-1:0] res_dom_ff, res_dom_in;
   logic [8:0]    res_size_ff, res_size_in;
   logic [1:0]    res_err_ff, res_err_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [23:0]   rsp_data_ff, rsp_data_in;
   logic [1:0]    rsp_user_ff, rsp_user_in;

   logic [VW-1:0] map_q;
   logic [IW-1:0] buf_q;
   logic          map_we, map_re;
   logic [AW-1:0] map_waddr;
   logic [VW-1:0] map_wdata;
   logic          buf_we, buf_re;

   logic [IW-1:0] req_idx;
   logic [VW-1:0] req_dom;
   logic          accept;
   logic          rsp_free;
   logic [DW-1:0] lim;
   logic          full;
   logic          bad;
   logic [VW-1:0] emit_dom;

   gllp_pkg::scan_ctrl_type ctrl;
   gllp_pkg::scan_stat_type status;
   logic [DW-1:0]           best;

   gllp_counts #(
      .MAX_DOMAINS(MAX_DOMAINS),
      .MAX_GROUPS (MAX_GROUPS)
   ) u_counts (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .lim   (lim),
      .status(status),
      .best  (best)
   );

   assign req_idx    = req_tdata[15:0];
   assign req_dom    = req_tdata[22:16];
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;
   assign active_in  = csr_valid ? csr_data : active_ff;

   assign lim      = (32'(active_ff) > MAX_DOMAINS) ? DW'(MAX_DOMAINS) : DW'(active_ff);
   assign full     = (32'(fill_ff) >= MAX_GROUP);
   assign bad      = (map_q == '0) || (32'(map_q) > 32'(lim));
   assign emit_dom = (res_kind_ff == gllp_pkg::KIND_READ) ? map_q : res_dom_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   always_comb begin
      state_in     = state_ff;
      last_in      = last_ff;
      idx_in       = idx_ff;
      fill_in      = fill_ff;
      fault_in     = fault_ff;
      rk_in        = rk_ff;
      rvld_in      = 1'b0;
      res_kind_in  = res_kind_ff;
      res_dom_in   = res_dom_ff;
      res_size_in  = res_size_ff;
      res_err_in   = res_err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      map_we       = 1'b0;
      map_re       = 1'b0;
      map_waddr    = req_idx[AW-1:0];
      map_wdata    = req_dom;
      buf_we       = 1'b0;
      buf_re       = 1'b0;
      ctrl         = '0;
      ctrl.mark_dom = map_q;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               idx_in  = req_idx;
               last_in = req_tlast;
               unique case (req_tuser)
                  gllp_pkg::OP_WRITE: begin
                     map_we = 1'b1;
                  end
                  gllp_pkg::OP_CLEAR: begin
                     ctrl.clear_counts = 1'b1;
                  end
                  gllp_pkg::OP_READ: begin
                     map_re      = 1'b1;
                     res_kind_in = gllp_pkg::KIND_READ;
                     res_size_in = '0;
                     res_err_in  = gllp_pkg::ERR_NONE;
                     state_in    = ST_EMIT;
                  end
                  gllp_pkg::OP_MEMBER: begin
                     map_re   = 1'b1;
                     state_in = ST_MEMB;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_MEMB: begin
            if (full) begin
               if (fault_ff == gllp_pkg::ERR_NONE) begin
                  fault_in = gllp_pkg::ERR_OVERFLOW;
               end
            end else begin
               buf_we  = 1'b1;
               fill_in = fill_ff + FW'(1);
               if (bad) begin
                  if (fault_ff == gllp_pkg::ERR_NONE) begin
                     fault_in = gllp_pkg::ERR_DOMAIN;
                  end
               end else begin
                  ctrl.mark = 1'b1;
               end
            end
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (fault_in != gllp_pkg::ERR_NONE) begin
               res_kind_in    = gllp_pkg::KIND_DROPPED;
               res_dom_in     = '0;
               res_size_in    = '0;
               res_err_in     = fault_in;
               fill_in        = '0;
               fault_in       = gllp_pkg::ERR_NONE;
               ctrl.clear_occ = 1'b1;
               state_in       = ST_EMIT;
            end else begin
               ctrl.start = 1'b1;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.done) begin
               if (status.found) begin
                  res_kind_in = gllp_pkg::KIND_PLACED;
                  res_dom_in  = VW'(best);
                  res_size_in = 9'(fill_ff);
                  res_err_in  = gllp_pkg::ERR_NONE;
                  rk_in       = '0;
                  state_in    = ST_REWR;
               end else begin
                  res_kind_in    = gllp_pkg::KIND_DROPPED;
                  res_dom_in     = '0;
                  res_size_in    = '0;
                  res_err_in     = gllp_pkg::ERR_DOMAIN;
                  fill_in        = '0;
                  fault_in       = gllp_pkg::ERR_NONE;
                  ctrl.clear_occ = 1'b1;
                  state_in       = ST_EMIT;
               end
            end
         end
         ST_REWR: begin
            if (rk_ff != fill_ff) begin
               buf_re  = 1'b1;
               rk_in   = rk_ff + FW'(1);
               rvld_in = 1'b1;
            end
            if (rvld_ff) begin
               map_we    = 1'b1;
               map_waddr = buf_q[AW-1:0];
               map_wdata = res_dom_ff;
            end
            if ((rk_ff == fill_ff) && !rvld_ff) begin
               fill_in        = '0;
               fault_in       = gllp_pkg::ERR_NONE;
               ctrl.clear_occ = 1'b1;
               state_in       = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'd0, res_err_ff, res_size_ff, emit_dom};
               rsp_user_in  = res_kind_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[map_waddr] <= map_wdata;
      end else if (map_re) begin
         map_q <= map_mem[req_idx[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_mem[fill_ff[BW-1:0]] <= idx_ff;
      end else if (buf_re) begin
         buf_q <= buf_mem[rk_ff[BW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= 7'd1;
         fill_ff      <= '0;
         fault_ff     <= gllp_pkg::ERR_NONE;
         rvld_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         fill_ff      <= fill_in;
         fault_ff     <= fault_in;
         rvld_ff      <= rvld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff     <= last_in;
      idx_ff      <= idx_in;
      rk_ff       <= rk_in;
      res_kind_ff <= res_kind_in;
      res_dom_ff  <= res_dom_in;
      res_size_ff <= res_size_in;
      res_err_ff  <= res_err_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   `ASSERT_NEXT(a_member_next, clock, reset,
                accept && req_tuser == gllp_pkg::OP_MEMBER, state_ff == ST_MEMB)
   `ASSERT_IMPL(a_fill_bound, clock, reset, 1'b1, 32'(fill_ff) <= MAX_GROUP)
   `ASSERT_IMPL(a_rewrite_ok, clock, reset, state_ff == ST_REWR,
                fill_ff != '0 && res_kind_ff == gllp_pkg::KIND_PLACED)

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Testbench of group_least_loaded_domain_placer: directed table, then random phases
// checked against a cycle-free predictor of map, group counts and group buffer.
// Depends on gllp_pkg and the placer RTL.
module tb;

   localparam int unsigned STALL_LIMIT = 4000;
   localparam int unsigned IDLE_PAUSE  = 32;
   localparam int unsigned PHASE_ITEMS = 200;

   typedef struct packed {
      logic [1:0]                  kind;
      logic [gllp_pkg::DOM_W-1:0]  dom;
      logic [gllp_pkg::SIZE_W-1:0] size;
      logic [1:0]                  err;
   } placement_type;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type               kind;
      logic [1:0]                 op;
      logic [15:0]                idx;
      logic [gllp_pkg::DOM_W-1:0] dom;
      logic                       last;
      logic                       has_want;
      placement_type              want;
   } stim_row_type;

   localparam placement_type NO_RESULT = '0;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic [1:0]  req_tuser = gllp_pkg::OP_WRITE;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [6:0]  csr_data = 7'd1;

   group_least_loaded_domain_placer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // Predicted state of the block.
   logic [gllp_pkg::DOM_W-1:0] elem_domain [0:65535];
   int unsigned                domain_load [1:64];
   bit                         domain_used [1:64];
   logic [15:0]                group_members [0:255];
   int unsigned                group_fill;
   logic [1:0]                 group_fault;
   logic [6:0]                 active_cfg;

   bit               ever_written [0:65535];
   logic [15:0]      known_elems [$];
   placement_type    expected_placements [$];

   int unsigned items_sent, results_seen, mismatches, quiet_cycles;
   int unsigned map_reads, groups_placed, groups_dropped, overflow_drops, settings_used;
   int unsigned long_hold;
   bit          req_calm, rsp_calm;

   stim_row_type directed_rows [0:24] = '{
      '{ROW_ITEM, gllp_pkg::OP_WRITE,  16'h0000, 7'd1,   1'b0, 1'b0, NO_RESULT},
      '{ROW_ITEM, gllp_pkg::OP_READ,   16'h0000, 7'd0,   1'b0, 1'b1,
        '{gllp_pkg::KIND_READ, 7'd1, 9'd0, gllp_pkg::ERR_NONE}},
      '{ROW_ITEM, gllp_pkg::OP_WRITE,  16'hFFFF, 7'd127, 1'b0, 1'b0, NO_RESULT},
      '{ROW_ITEM, gllp_pkg::OP_READ,   16'hFFFF, 7'd0,   1'b1, 1'b1,
        '{gllp_pkg::KIND_READ, 7'd127, 9'd0, gllp_pkg::ERR_NONE}},
      '{ROW_ITEM, gllp_pkg::OP_MEMBER, 16'hFFFF, 7'd0,   1'b1, 1'b1,
        '{gllp_pkg::KIND_DROPPED, 7'd0, 9'd0, gllp_pkg::ERR_DOMAIN}},
      '{ROW_ITEM, gllp_pkg::OP_MEMBER, 16'h0000, 7'd127, 1'b1, 1'b1,
        '{gllp_pkg::KIND_PLACED, 7'd1, 9'd1, gllp_pkg::ERR_NONE}},
      '{ROW_ITEM, gllp_pkg::OP_WRITE,  16'h00FF, 7'd0,   1'b1, 1'b0, NO_RESULT},
      '{ROW_ITEM, gllp_pkg::OP_MEMBER, 16'h00FF, 7'd0,   1'b0, 1'b0, NO_RESULT},
      '{ROW_ITEM, gllp_pkg::OP_MEMBER, 16'h0000, 7'd0,   1'b1, 1'b1,
        '{gllp_pkg::KIND_DROPPED, 7'd0, 9'd0, gllp_pkg::ERR_DOMAIN}},
      '{ROW_ITEM, gllp_pkg::OP_CLEAR,  16'hAAAA, 7'd85,  1'b1, 1'b0, NO_RESULT},
      '{ROW_ITEM, gllp_pkg::OP_WRITE,  16'hAAAA, 7'd1,   1'b1, 1'b0, NO_RESULT},
      '{ROW_ITEM, gllp_pkg::OP_MEMBER, 16'hAAAA, 7'd0,   1'b0, 1'b0, NO_RESULT},
      '{ROW_ITEM, gllp_pkg::OP_MEMBER, 16'h0000, 7'd0,   1'b1, 1'b1,
        '{gllp_pkg::KIND_PLACED, 7'd1, 9'd2, gllp_pkg::ERR_NONE}},
      '{ROW_CSR,  gllp_pkg::OP_WRITE,  16'h0000, 7'd64,  1'b0, 1'b0, NO_RESULT},
      '{ROW_ITEM, gllp_pkg::OP_WRITE,  16'h1234, 7'd64,  1'b0, 1'b0, NO_RESULT},
      '{ROW_ITEM, gllp_pkg::OP_WRITE,  16'h5678, 7'd2,   1'b0, 1'b0, NO_RESULT},
      '{ROW_ITEM, gllp_pkg::OP_MEMBER, 16'h1234, 7'd0,   1'b0, 1'b0, NO_RESULT},
      '{ROW_ITEM, gllp_pkg::OP_MEMBER, 16'h5678, 7'd0,   1'b1, 1'b1,
        '{gllp_pkg::KIND_PLACED, 7'd2, 9'd2, gllp_pkg::ERR_NONE}},
      '{ROW_ITEM, gllp_pkg::OP_READ,   16'h1234, 7'd0,   1'b0, 1'b1,
        '{gllp_pkg::KIND_READ, 7'd2, 9'd0, gllp_pkg::ERR_NONE}},
      '{ROW_ITEM, gllp_pkg::OP_WRITE,  16'h00FF, 7'd64,  1'b0, 1'b0, NO_RESULT},
      '{ROW_ITEM, gllp_pkg::OP_MEMBER, 16'h00FF, 7'd0,   1'b0, 1'b0, NO_RESULT},
      '{ROW_ITEM, gllp_pkg::OP_MEMBER, 16'h1234, 7'd0,   1'b1, 1'b0, NO_RESULT},
      '{ROW_CSR,  gllp_pkg::OP_WRITE,  16'h0000, 7'd127, 1'b0, 1'b0, NO_RESULT},
      '{ROW_ITEM, gllp_pkg::OP_READ,   16'hFFFF, 7'd0,   1'b0, 1'b1,
        '{gllp_pkg::KIND_READ, 7'd127, 9'd0, gllp_pkg::ERR_NONE}},
      '{ROW_ITEM, gllp_pkg::OP_MEMBER, 16'hFFFF, 7'd0,   1'b1, 1'b1,
        '{gllp_pkg::KIND_DROPPED, 7'd0, 9'd0, gllp_pkg::ERR_DOMAIN}}
   };

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned limit_now();
      return (active_cfg > gllp_pkg::MAX_DOMAINS_DEF) ? gllp_pkg::MAX_DOMAINS_DEF
                                                      : int'(active_cfg);
   endfunction

   function automatic logic [15:0] pick_known();
      return known_elems[$urandom_range(0, known_elems.size() - 1)];
   endfunction

   function automatic logic [gllp_pkg::DOM_W-1:0] pick_domain();
      int unsigned lim;
      lim = limit_now();
      if (lim != 0 && $urandom_range(0, 9) < 8)
         return 7'($urandom_range(1, lim));
      return 7'($urandom_range(0, 127));
   endfunction

   function automatic bit predict_placement(input logic [1:0] op, input logic [15:0] idx,
                                            input logic [gllp_pkg::DOM_W-1:0] dom,
                                            input logic last,
                                            output placement_type res);
      int unsigned lim, best;
      logic [gllp_pkg::DOM_W-1:0] cur;
      lim = limit_now();
      res = NO_RESULT;
      case (op)
         gllp_pkg::OP_WRITE: begin
            elem_domain[idx] = dom;
            return 1'b0;
         end
         gllp_pkg::OP_READ: begin
            res.kind = gllp_pkg::KIND_READ;
            res.dom = elem_domain[idx];
            map_reads++;
            return 1'b1;
         end
         gllp_pkg::OP_CLEAR: begin
            foreach (domain_load[d]) domain_load[d] = 0;
            return 1'b0;
         end
         default: ;
      endcase
      cur = elem_domain[idx];
      if (group_fill >= gllp_pkg::MAX_GROUP_DEF) begin
         if (group_fault == gllp_pkg::ERR_NONE) group_fault = gllp_pkg::ERR_OVERFLOW;
      end else begin
         group_members[group_fill] = idx;
         group_fill++;
         if (cur == 0 || cur > lim) begin
            if (group_fault == gllp_pkg::ERR_NONE) group_fault = gllp_pkg::ERR_DOMAIN;
         end else begin
            domain_used[cur] = 1'b1;
         end
      end
      if (!last) return 1'b0;
      best = 0;
      if (group_fault == gllp_pkg::ERR_NONE) begin
         for (int d = 1; d <= lim; d++)
            if (domain_used[d] && (best == 0 || domain_load[d] < domain_load[best]))
               best = d;
      end
      if (best == 0) begin
         res.kind = gllp_pkg::KIND_DROPPED;
         res.err = (group_fault == gllp_pkg::ERR_NONE) ? gllp_pkg::ERR_DOMAIN : group_fault;
         groups_dropped++;
         if (group_fault == gllp_pkg::ERR_OVERFLOW) overflow_drops++;
      end else begin
         if (domain_load[best] < gllp_pkg::MAX_GROUPS_DEF) domain_load[best]++;
         for (int k = 0; k < group_fill; k++) elem_domain[group_members[k]] = best[6:0];
         res.kind = gllp_pkg::KIND_PLACED;
         res.dom = best[6:0];
         res.size = group_fill[8:0];
         groups_placed++;
      end
      foreach (domain_used[d]) domain_used[d] = 1'b0;
      group_fill = 0;
      group_fault = gllp_pkg::ERR_NONE;
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what);
      $display("ERROR at %0t: %s", $time, what);
      mismatches++;
   endtask

   task automatic send_item(input logic [1:0] op, input logic [15:0] idx,
                            input logic [gllp_pkg::DOM_W-1:0] dom, input logic last,
                            input logic has_want, input placement_type want);
      int unsigned gap;
      placement_type predicted;
      gap = req_calm ? 0 : $urandom_range(0, 18);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {1'b0, dom, idx};
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (op == gllp_pkg::OP_WRITE && !ever_written[idx]) begin
         ever_written[idx] = 1'b1;
         known_elems.push_back(idx);
      end
      if (predict_placement(op, idx, dom, last, predicted))
         expected_placements.push_back(has_want ? want : predicted);
   endtask

   task automatic wait_block_idle();
      req_tvalid <= 1'b0;
      while (expected_placements.size() != 0) @(posedge clock);
      repeat (IDLE_PAUSE) @(posedge clock);
   endtask

   task automatic write_active_domains(input logic [6:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      active_cfg = value;
      settings_used++;
   endtask

   // Members are drawn from a few known elements; most groups first repair entries
   // that would fault, so that they reach the least-loaded choice.
   task automatic send_group(input int unsigned size, input bit leave_open);
      logic [15:0] picks [6];
      int unsigned n, lim;
      n = (size < 6) ? size : 6;
      lim = limit_now();
      for (int k = 0; k < n; k++) begin
         picks[k] = pick_known();
         if (lim != 0 && (elem_domain[picks[k]] == 0 || elem_domain[picks[k]] > lim) &&
             (leave_open || $urandom_range(0, 99) < 85))
            send_item(gllp_pkg::OP_WRITE, picks[k], 7'($urandom_range(1, lim)),
                      1'($urandom), 1'b0, NO_RESULT);
      end
      for (int k = 0; k < size; k++)
         send_item(gllp_pkg::OP_MEMBER, picks[k % n], 7'($urandom),
                   1'(!leave_open && k == size - 1), 1'b0, NO_RESULT);
   endtask

   task automatic random_action();
      int unsigned pick;
      logic [1:0] op;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         send_item(gllp_pkg::OP_WRITE, 16'($urandom), pick_domain(), 1'($urandom), 1'b0,
                   NO_RESULT);
      end else if (pick < 30) begin
         send_item(gllp_pkg::OP_READ, pick_known(), 7'($urandom), 1'($urandom), 1'b0,
                   NO_RESULT);
      end else if (pick < 34) begin
         send_item(gllp_pkg::OP_CLEAR, 16'($urandom), 7'($urandom), 1'($urandom), 1'b0,
                   NO_RESULT);
      end else if (pick < 88) begin
         send_group(($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8),
                    1'b0);
      end else begin
         op = 2'($urandom);
         send_item(op, (op == gllp_pkg::OP_WRITE) ? 16'($urandom) : pick_known(),
                   7'($urandom), 1'($urandom), 1'b0, NO_RESULT);
      end
   endtask

   task automatic check_result();
      placement_type want;
      if (expected_placements.size() == 0) begin
         report_mismatch($sformatf("result with nothing expected, kind %0d", rsp_tuser));
         return;
      end
      want = expected_placements.pop_front();
      results_seen++;
      if (rsp_tuser != want.kind)
         report_mismatch($sformatf("result %0d kind: got %0d, want %0d",
                                   results_seen, rsp_tuser, want.kind));
      if (rsp_tdata[6:0] != want.dom)
         report_mismatch($sformatf("result %0d domain: got %0d, want %0d",
                                   results_seen, rsp_tdata[6:0], want.dom));
      if (rsp_tdata[15:7] != want.size)
         report_mismatch($sformatf("result %0d group size: got %0d, want %0d",
                                   results_seen, rsp_tdata[15:7], want.size));
      if (rsp_tdata[17:16] != want.err)
         report_mismatch($sformatf("result %0d error code: got %0d, want %0d",
                                   results_seen, rsp_tdata[17:16], want.err));
   endtask

   initial begin : result_sink
      int unsigned stall;
      do @(posedge clock); while (reset);
      forever begin
         if (long_hold != 0) begin
            stall = long_hold;
            long_hold = 0;
         end else begin
            stall = rsp_calm ? 0 : $urandom_range(0, 18);
         end
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         check_result();
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Timeout: no transaction for %0d cycles, %0d results outstanding.",
                  quiet_cycles, expected_placements.size());
         $display("tb NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [6:0] phase_cfg [8];
      int unsigned phase_end;
      foreach (domain_load[d]) begin
         domain_load[d] = 0;
         domain_used[d] = 1'b0;
      end
      group_fill = 0;
      group_fault = gllp_pkg::ERR_NONE;
      active_cfg = 7'd1;
      phase_cfg = '{7'd64, 7'd3, 7'd127, 7'd0, 7'd1, 7'd64, 7'd0, 7'd0};
      phase_cfg[6] = 7'($urandom_range(1, 64));
      phase_cfg[7] = 7'($urandom_range(0, 127));
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_CSR) begin
            wait_block_idle();
            write_active_domains(directed_rows[r].dom);
         end else begin
            send_item(directed_rows[r].op, directed_rows[r].idx, directed_rows[r].dom,
                      directed_rows[r].last, directed_rows[r].has_want, directed_rows[r].want);
         end
      end

      for (int p = 0; p < 8; p++) begin
         wait_block_idle();
         write_active_domains(phase_cfg[p]);
         req_calm = ($urandom_range(0, 3) == 0);
         rsp_calm = ($urandom_range(0, 3) == 0);
         phase_end = items_sent + PHASE_ITEMS;
         if (p == 0) send_group(gllp_pkg::MAX_GROUP_DEF, 1'b0);
         if (p == 5) send_group(gllp_pkg::MAX_GROUP_DEF + 2, 1'b0);
         if (p == 2) begin
            long_hold = 300;
            repeat (25)
               send_item(gllp_pkg::OP_READ, pick_known(), 7'($urandom), 1'b0, 1'b0,
                         NO_RESULT);
         end
         while (items_sent < phase_end) random_action();
         // A group left open here is finished under the next setting.
         if ($urandom_range(0, 1) == 1 && limit_now() != 0)
            send_group($urandom_range(1, 3), 1'b1);
      end

      wait_block_idle();
      $display("Sent %0d transactions under %0d domain settings; checked %0d results.",
               items_sent, settings_used, results_seen);
      $display("Map reads %0d, groups placed %0d, dropped %0d (%0d on buffer overflow).",
               map_reads, groups_placed, groups_dropped, overflow_drops);
      if (mismatches == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule

### group_least_loaded_domain_placer.f
+incdir+rtl
rtl/gllp_pkg.sv
rtl/gllp_counts.sv
rtl/group_least_loaded_domain_placer.sv
tb/tb.sv
